>>> sv/ecm_pkg.sv
`default_nettype none
package ecm_pkg;

   // result segment codes
   localparam logic [1:0] SEG_DEFAULT   = 2'd0;
   localparam logic [1:0] SEG_EASE_IN   = 2'd1;
   localparam logic [1:0] SEG_EASE_OUT  = 2'd2;
   localparam logic [1:0] SEG_CROSSFADE = 2'd3;

   // register indexes
   localparam logic [2:0] REG_MODE      = 3'd0;
   localparam logic [2:0] REG_IN_START  = 3'd1;
   localparam logic [2:0] REG_IN_END    = 3'd2;
   localparam logic [2:0] REG_OUT_START = 3'd3;
   localparam logic [2:0] REG_OUT_END   = 3'd4;
   localparam logic [2:0] REG_IN_PTS    = 3'd5;
   localparam logic [2:0] REG_OUT_PTS   = 3'd6;

   localparam int DIV_STEPS = 16;
   localparam logic [16:0] ONE_Q16 = 17'h10000;

   // division job travelling with an item
   typedef struct packed {
      logic [1:0]  seg;      // chosen segment
      logic        use_div;  // quotient is needed
      logic [16:0] fixed_t;  // position when no division is needed
      logic [32:0] num;      // numerator, 0 < num < den when use_div
      logic [32:0] den;
      logic [31:0] pts;      // control bytes for the curve
      logic [7:0]  fade_a;   // crossfade start byte (ease-out P3)
      logic [7:0]  fade_b;   // crossfade end byte (ease-in P0)
   } job_type;

endpackage
`default_nettype wire

>>> sv/ecm_divider.sv
`default_nettype none
// pipelined restoring divider, one quotient bit per stage, 16 stages
module ecm_divider (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                in_valid,
   input  wire ecm_pkg::job_type    in_job,
   output logic                     out_valid,
   output ecm_pkg::job_type         out_job,
   output logic [16:0]              out_t
);
   localparam int N = ecm_pkg::DIV_STEPS;

   logic             valid_ff [N];
   ecm_pkg::job_type job_ff   [N];
   logic [33:0]      rem_ff   [N];
   logic [15:0]      quo_ff   [N];

   // stage 0 shifts the first bit in
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) valid_ff[i] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < N; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         logic [33:0] r0;
         r0 = {in_job.num, 1'b0};
         job_ff[0] <= in_job;
         if (r0 >= {1'b0, in_job.den}) begin
            rem_ff[0] <= r0 - {1'b0, in_job.den};
            quo_ff[0] <= 16'd1;
         end else begin
            rem_ff[0] <= r0;
            quo_ff[0] <= 16'd0;
         end
         for (int i = 1; i < N; i++) begin
            logic [33:0] r;
            r = {rem_ff[i-1][32:0], 1'b0};
            job_ff[i] <= job_ff[i-1];
            if (r >= {1'b0, job_ff[i-1].den}) begin
               rem_ff[i] <= r - {1'b0, job_ff[i-1].den};
               quo_ff[i] <= {quo_ff[i-1][14:0], 1'b1};
            end else begin
               rem_ff[i] <= r;
               quo_ff[i] <= {quo_ff[i-1][14:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_job   = job_ff[N-1];
   assign out_t     = job_ff[N-1].use_div ? {1'b0, quo_ff[N-1]} : job_ff[N-1].fixed_t;
endmodule
`default_nettype wire

>>> sv/ease_curve_multiplier.sv
// path: a transferred req passes stages A and B, the divider, stages C, D and F and the output register to rsp valid
// throughput: one item per cycle while the output is not stalled; a 16-stage bit-per-stage divider sets the depth
// the whole pipeline advances together; a stall holds every stage
// reset: synchronous, active high; clears valid bits and loads register defaults
`default_nettype none
module ease_curve_multiplier (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_current_time,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [16:0]             rsp_multiplier,
   output logic [1:0]              rsp_segment,
   input  wire logic               csr_write_enable,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_write_data
);
   // configuration registers
   logic [1:0]         mode_ff;
   logic signed [31:0] in_start_ff, in_end_ff, out_start_ff, out_end_ff;
   logic [31:0]        in_pts_ff, out_pts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 2'd0;
         in_start_ff  <= '0;
         in_end_ff    <= '0;
         out_start_ff <= '0;
         out_end_ff   <= '0;
         in_pts_ff    <= 32'hFFFF0000;
         out_pts_ff   <= 32'h0000FFFF;
      end else if (csr_write_enable) begin
         case (csr_index)
            ecm_pkg::REG_MODE:      mode_ff      <= csr_write_data[1:0];
            ecm_pkg::REG_IN_START:  in_start_ff  <= csr_write_data;
            ecm_pkg::REG_IN_END:    in_end_ff    <= csr_write_data;
            ecm_pkg::REG_OUT_START: out_start_ff <= csr_write_data;
            ecm_pkg::REG_OUT_END:   out_end_ff   <= csr_write_data;
            ecm_pkg::REG_IN_PTS:    in_pts_ff    <= csr_write_data;
            ecm_pkg::REG_OUT_PTS:   out_pts_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // global advance: whole pipe moves unless the output holds a result not taken
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // stage A: register time and the comparisons
   logic               a_valid_ff;
   logic signed [32:0] a_now_ff;
   logic               a_gt_oe_ff, a_gt_is_ff, a_le_ie_ff, a_ge_os_ff;

   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else if (advance) a_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_now_ff   <= 33'(req_current_time);
         a_gt_oe_ff <= req_current_time >  out_end_ff;
         a_gt_is_ff <= req_current_time >  in_start_ff;
         a_le_ie_ff <= req_current_time <= in_end_ff;
         a_ge_os_ff <= req_current_time >= out_start_ff;
      end
   end

   // stage B: choose the segment and build the division job
   ecm_pkg::job_type b_job_in;
   logic             b_valid_ff;
   ecm_pkg::job_type b_job_ff;

   always_comb begin
      logic               in_on, out_on, use_in;
      logic signed [32:0] s, e, num, den;
      in_on  = mode_ff[0];
      out_on = mode_ff[1];
      b_job_in = '0;
      b_job_in.fade_a = out_pts_ff[31:24];
      b_job_in.fade_b = in_pts_ff[7:0];
      use_in = 1'b0;
      if (in_on && out_on && (in_start_ff >= out_start_ff)) begin
         if (a_gt_oe_ff) begin
            if (a_gt_is_ff) begin
               if (a_le_ie_ff) begin
                  b_job_in.seg = ecm_pkg::SEG_EASE_IN;
                  use_in = 1'b1;
               end else begin
                  b_job_in.seg = ecm_pkg::SEG_DEFAULT;
               end
            end else begin
               b_job_in.seg = ecm_pkg::SEG_CROSSFADE;
            end
         end else begin
            b_job_in.seg = ecm_pkg::SEG_EASE_OUT;
         end
      end else begin
         b_job_in.seg = ecm_pkg::SEG_DEFAULT;
         if (out_on && a_ge_os_ff) b_job_in.seg = ecm_pkg::SEG_EASE_OUT;
         if (in_on && a_le_ie_ff) begin
            b_job_in.seg = ecm_pkg::SEG_EASE_IN;
            use_in = 1'b1;
         end
      end
      // window ends for the chosen segment
      if (b_job_in.seg == ecm_pkg::SEG_CROSSFADE) begin
         s = 33'(out_end_ff);
         e = 33'(in_start_ff);
      end else if (use_in) begin
         s = 33'(in_start_ff);
         e = 33'(in_end_ff);
      end else begin
         s = 33'(out_start_ff);
         e = 33'(out_end_ff);
      end
      b_job_in.pts = use_in ? in_pts_ff : out_pts_ff;
      den = e - s;
      num = a_now_ff - s;
      if (den == 33'sd0) begin
         b_job_in.fixed_t = (a_now_ff < s) ? 17'd0 : ecm_pkg::ONE_Q16;
      end else begin
         if (den < 0) begin
            den = -den;
            num = -num;
         end
         if (num <= 0) b_job_in.fixed_t = 17'd0;
         else if (num >= den) b_job_in.fixed_t = ecm_pkg::ONE_Q16;
         else b_job_in.use_div = 1'b1;
      end
      b_job_in.num = num;
      b_job_in.den = den;
   end

   always_ff @(posedge clock) begin
      if (reset) b_valid_ff <= 1'b0;
      else if (advance) b_valid_ff <= a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) b_job_ff <= b_job_in;
   end

   // divider stages
   logic             d_valid;
   ecm_pkg::job_type d_job;
   logic [16:0]      d_t;

   ecm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (b_valid_ff),
      .in_job   (b_job_ff),
      .out_valid(d_valid),
      .out_job  (d_job),
      .out_t    (d_t)
   );

   // stage C: powers of t and u
   logic        c_valid_ff;
   logic [1:0]  c_seg_ff;
   logic [31:0] c_pts_ff;
   logic [7:0]  c_fa_ff, c_fb_ff;
   logic [16:0] c_t_ff, c_u_ff;
   logic [33:0] c_tt_ff, c_uu_ff, c_ut_ff;

   always_ff @(posedge clock) begin
      if (reset) c_valid_ff <= 1'b0;
      else if (advance) c_valid_ff <= d_valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         logic [16:0] u;
         u = ecm_pkg::ONE_Q16 - d_t;
         c_seg_ff <= d_job.seg;
         c_pts_ff <= d_job.pts;
         c_fa_ff  <= d_job.fade_a;
         c_fb_ff  <= d_job.fade_b;
         c_t_ff   <= d_t;
         c_u_ff   <= u;
         c_tt_ff  <= d_t * d_t;
         c_uu_ff  <= u * u;
         c_ut_ff  <= u * d_t;
      end
   end

   // stage D: basis weights (each below 2^50), crossfade products
   logic        e_valid_ff;
   logic [1:0]  e_seg_ff;
   logic [31:0] e_pts_ff;
   logic [50:0] e_w0_ff, e_w1_ff, e_w2_ff, e_w3_ff;
   logic [33:0] e_fade_ff;

   always_ff @(posedge clock) begin
      if (reset) e_valid_ff <= 1'b0;
      else if (advance) e_valid_ff <= c_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e_seg_ff  <= c_seg_ff;
         e_pts_ff  <= c_pts_ff;
         e_w0_ff   <= 51'(c_uu_ff * c_u_ff);
         e_w1_ff   <= 51'(c_uu_ff * c_t_ff) * 51'd3;
         e_w2_ff   <= 51'(c_tt_ff * c_u_ff) * 51'd3;
         e_w3_ff   <= 51'(c_tt_ff * c_t_ff);
         // crossfade: position in c_t, ends in bytes times 257
         e_fade_ff <= 34'(c_u_ff * (17'(c_fa_ff) * 17'd257))
                    + 34'(c_t_ff * (17'(c_fb_ff) * 17'd257)) + 34'd32768;
      end
   end

   // stage F: weighted control bytes (multiply by byte, times 257 later)
   logic        f_valid_ff;
   logic [1:0]  f_seg_ff;
   logic [60:0] f_sum_ff;
   logic [16:0] f_fade_ff;

   always_ff @(posedge clock) begin
      if (reset) f_valid_ff <= 1'b0;
      else if (advance) f_valid_ff <= e_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f_seg_ff  <= e_seg_ff;
         f_sum_ff  <= 61'(e_w0_ff * e_pts_ff[7:0])   + 61'(e_w1_ff * e_pts_ff[15:8])
                    + 61'(e_w2_ff * e_pts_ff[23:16]) + 61'(e_w3_ff * e_pts_ff[31:24]);
         f_fade_ff <= e_fade_ff[32:16];
      end
   end

   // stage G: scale by 257, round, select (the weighted sum stays below 2^56)
   logic [16:0] out_mult_in;

   always_comb begin
      logic [63:0] full;
      full = {f_sum_ff[55:0], 8'd0} + 64'(f_sum_ff) + 64'h0000_8000_0000_0000;
      case (f_seg_ff)
         ecm_pkg::SEG_DEFAULT:   out_mult_in = ecm_pkg::ONE_Q16;
         ecm_pkg::SEG_CROSSFADE: out_mult_in = f_fade_ff;
         default:                out_mult_in = {1'b0, full[63:48]};
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (advance) rsp_valid <= f_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_multiplier <= out_mult_in;
         rsp_segment    <= f_seg_ff;
      end
   end

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_multiplier))
      else $error("stalled result changed");

   // only the default segment reaches 1.0
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_multiplier[16] |-> rsp_segment == ecm_pkg::SEG_DEFAULT)
      else $error("curve value above one");

   // quotient stage sees a proper fraction
   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && b_job_ff.use_div |-> b_job_ff.num < b_job_ff.den)
      else $error("divider operand out of range");
endmodule
`default_nettype wire
